// ===== src/dsi_pkg.sv =====
`default_nettype none

package dsi_pkg;

	// Parse phases of the character stream.
	typedef enum logic [2:0] {
		PH_LEAD   = 3'd0,
		PH_INNER  = 3'd1,
		PH_PREFIX = 3'd2,
		PH_ZERO   = 3'd3,
		PH_DIGITS = 3'd4,
		PH_ERROR  = 3'd5
	} phase_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	// Configuration registers as seen by the parser.
	typedef struct packed {
		logic [4:0] base;
		logic       signed_mode;
	} cfg_t;

	// Register indexes on the configuration port.
	localparam logic REG_BASE   = 1'b0;
	localparam logic REG_SIGNED = 1'b1;

	// Characters that the parser looks for.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_F_UP  = 8'h46;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_F_LO  = 8'h66;
	localparam logic [7:0] CH_X_LO  = 8'h78;

	// Bases.
	localparam logic [4:0] BASE_AUTO = 5'd0;
	localparam logic [4:0] BASE_MIN  = 5'd2;
	localparam logic [4:0] BASE_OCT  = 5'd8;
	localparam logic [4:0] BASE_DEC  = 5'd10;
	localparam logic [4:0] BASE_HEX  = 5'd16;

	// Space, tab, line feed, vertical tab, form feed and carriage return.
	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	// Returns {valid, digit} for 0-9, a-f and A-F.
	function automatic logic [4:0] digit_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
			r = {1'b1, 4'(c - CH_ZERO)};
		end else if ((c >= CH_A_LO) && (c <= CH_F_LO)) begin
			r = {1'b1, 4'(c - CH_A_LO + 8'd10)};
		end else if ((c >= CH_A_UP) && (c <= CH_F_UP)) begin
			r = {1'b1, 4'(c - CH_A_UP + 8'd10)};
		end
		return r;
	endfunction

	// The first error of a string is the one that is reported.
	function automatic status_t first_err(input status_t cur, input status_t code);
		return (cur == ST_OK) ? code : cur;
	endfunction

endpackage

`default_nettype wire

// ===== src/dsi_stream_ifs.sv =====
`default_nettype none

// Character request channel.
interface dsi_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

// Result request channel.
interface dsi_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ===== src/dsi_step.sv =====
`default_nettype none

// Parser state and the one-character step. The state advances on every
// fired character; the result is formed from the state the terminator sees.
module dsi_step #(
	parameter int VALUE_WIDTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [7:0]        ch,
	input  wire dsi_pkg::cfg_t     cfg,
	output logic [63:0]            res_value,
	output dsi_pkg::status_t       res_status
);

	localparam int PW = VALUE_WIDTH + 5;
	localparam logic [VALUE_WIDTH-1:0] HALF = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	dsi_pkg::phase_t          phase_q, phase_d;
	logic [VALUE_WIDTH-1:0]   acc_q, acc_d;
	logic                     neg_q, neg_d;
	logic [4:0]               ab_q, ab_d;
	dsi_pkg::status_t         err_q, err_d;
	logic                     ds_q, ds_d;

	logic                     term;
	logic [4:0]               dig;
	logic [4:0]               mul_base;
	logic [PW-1:0]            prod;

	assign term = (ch == dsi_pkg::CH_NUL);
	assign dig  = dsi_pkg::digit_decode(ch);

	// Base in force when a digit is taken: set this cycle or held from before.
	always_comb begin
		mul_base = ab_q;
		if ((phase_q == dsi_pkg::PH_LEAD) || (phase_q == dsi_pkg::PH_INNER) ||
		    (phase_q == dsi_pkg::PH_PREFIX)) begin
			mul_base = (cfg.base == dsi_pkg::BASE_AUTO) ? dsi_pkg::BASE_DEC : cfg.base;
		end else if (phase_q == dsi_pkg::PH_ZERO) begin
			mul_base = dsi_pkg::BASE_OCT;
		end
	end

	// Multiply-add by the base with headroom; any bit above the value width is overflow.
	assign prod = PW'(acc_q) * PW'(mul_base) + PW'(dig[3:0]);

	// Next state for one character, walking the phases in order.
	always_comb begin
		logic done;
		done    = 1'b0;
		phase_d = phase_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		ab_d    = ab_q;
		err_d   = err_q;
		ds_d    = ds_q;
		if (term) begin
			phase_d = dsi_pkg::PH_LEAD;
			acc_d   = '0;
			neg_d   = 1'b0;
			ab_d    = dsi_pkg::BASE_AUTO;
			err_d   = dsi_pkg::ST_OK;
			ds_d    = 1'b0;
		end else begin
			if (phase_d == dsi_pkg::PH_LEAD) begin
				if (dsi_pkg::is_ws(ch)) begin
					done = 1'b1;
				end else if (cfg.signed_mode) begin
					phase_d = dsi_pkg::PH_INNER;
					if (ch == dsi_pkg::CH_MINUS) begin
						neg_d = 1'b1;
						done  = 1'b1;
					end else if (ch == dsi_pkg::CH_PLUS) begin
						done = 1'b1;
					end
				end else begin
					if (ch == dsi_pkg::CH_MINUS) begin
						err_d   = dsi_pkg::first_err(err_d, dsi_pkg::ST_INVALID);
						phase_d = dsi_pkg::PH_ERROR;
						done    = 1'b1;
					end else begin
						phase_d = dsi_pkg::PH_PREFIX;
						done    = (ch == dsi_pkg::CH_PLUS);
					end
				end
			end
			if (!done && (phase_d == dsi_pkg::PH_INNER)) begin
				if (dsi_pkg::is_ws(ch)) begin
					done = 1'b1;
				end else if (ch == dsi_pkg::CH_MINUS) begin
					err_d   = dsi_pkg::first_err(err_d, dsi_pkg::ST_INVALID);
					phase_d = dsi_pkg::PH_ERROR;
					done    = 1'b1;
				end else begin
					phase_d = dsi_pkg::PH_PREFIX;
					done    = (ch == dsi_pkg::CH_PLUS);
				end
			end
			if (!done && (phase_d == dsi_pkg::PH_PREFIX)) begin
				if (cfg.base == dsi_pkg::BASE_AUTO) begin
					if (ch == dsi_pkg::CH_ZERO) begin
						phase_d = dsi_pkg::PH_ZERO;
						ds_d    = 1'b1;
						done    = 1'b1;
					end else begin
						ab_d    = dsi_pkg::BASE_DEC;
						phase_d = dsi_pkg::PH_DIGITS;
					end
				end else if ((cfg.base < dsi_pkg::BASE_MIN) ||
				             (cfg.base > dsi_pkg::BASE_HEX)) begin
					err_d   = dsi_pkg::first_err(err_d, dsi_pkg::ST_INVALID);
					phase_d = dsi_pkg::PH_ERROR;
					done    = 1'b1;
				end else begin
					ab_d    = cfg.base;
					phase_d = dsi_pkg::PH_DIGITS;
				end
			end
			if (!done && (phase_d == dsi_pkg::PH_ZERO)) begin
				if ((ch == dsi_pkg::CH_X_LO) || (ch == dsi_pkg::CH_X_UP)) begin
					ab_d    = dsi_pkg::BASE_HEX;
					ds_d    = 1'b0;
					phase_d = dsi_pkg::PH_DIGITS;
					done    = 1'b1;
				end else begin
					ab_d    = dsi_pkg::BASE_OCT;
					phase_d = dsi_pkg::PH_DIGITS;
				end
			end
			if (!done && (phase_d == dsi_pkg::PH_DIGITS)) begin
				if (!dig[4] || (ab_d < dsi_pkg::BASE_MIN) || ({1'b0, dig[3:0]} >= ab_d)) begin
					err_d   = dsi_pkg::first_err(err_d, dsi_pkg::ST_INVALID);
					phase_d = dsi_pkg::PH_ERROR;
				end else if (prod[PW-1:VALUE_WIDTH] != '0) begin
					err_d   = dsi_pkg::first_err(err_d, dsi_pkg::ST_RANGE);
					phase_d = dsi_pkg::PH_ERROR;
				end else begin
					acc_d = prod[VALUE_WIDTH-1:0];
					ds_d  = 1'b1;
				end
			end
		end
	end

	// Result as a terminator would see it in the current state.
	always_comb begin
		logic [VALUE_WIDTH-1:0] mag;
		logic [VALUE_WIDTH-1:0] v;
		dsi_pkg::status_t       st;
		st  = err_q;
		mag = (phase_q == dsi_pkg::PH_ZERO) ? '0 : acc_q;
		v   = mag;
		if ((st == dsi_pkg::ST_OK) && (phase_q != dsi_pkg::PH_ZERO) &&
		    ((phase_q != dsi_pkg::PH_DIGITS) || !ds_q)) begin
			st = dsi_pkg::ST_INVALID;
		end
		if ((st == dsi_pkg::ST_OK) && cfg.signed_mode) begin
			if (neg_q) begin
				if (mag > HALF) begin
					st = dsi_pkg::ST_RANGE;
				end else begin
					v = '0 - mag;
				end
			end else if (mag > HALF - 1'b1) begin
				st = dsi_pkg::ST_RANGE;
			end
		end
		res_status = st;
		if (st != dsi_pkg::ST_OK) begin
			res_value = '0;
		end else if (cfg.signed_mode) begin
			res_value = 64'($signed(v));
		end else begin
			res_value = 64'(v);
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dsi_pkg::PH_LEAD;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			ab_q    <= dsi_pkg::BASE_AUTO;
			err_q   <= dsi_pkg::ST_OK;
			ds_q    <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			ab_q    <= ab_d;
			err_q   <= err_d;
			ds_q    <= ds_d;
		end
	end

	// An error phase always carries the error that caused it.
	a_err_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == dsi_pkg::PH_ERROR) |-> (err_q != dsi_pkg::ST_OK))
		else $error("error phase without an error code");

	// Digits are only taken with a usable base.
	a_digit_base: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == dsi_pkg::PH_DIGITS) |-> ((ab_q >= dsi_pkg::BASE_MIN) &&
		(ab_q <= dsi_pkg::BASE_HEX)))
		else $error("digit phase with a bad base");

endmodule

`default_nettype wire

// ===== src/digit_string_to_integer.sv =====
// Streaming string-to-integer parser. One character is accepted on din per
// clock unless stalled; a zero byte ends the string and yields one result
// (value, status) on dout, 0 ok, 1 invalid, 2 out of range. A character is
// registered in the input register on acceptance and processed by the
// one-character step logic as it leaves that register; a terminator's result
// is then loaded into the output register. The sustained rate is one
// character per cycle outside the only stall, a terminator held in the input
// register while the previous result is still unclaimed in the output
// register. The base and signed_mode registers sit on the APB port at byte
// addresses 0 and 4 and should be written while no string is in flight.
`default_nettype none

module digit_string_to_integer #(
	parameter int VALUE_WIDTH = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	dsi_char_if.sink           din,
	dsi_result_if.source       dout,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	dsi_pkg::cfg_t     cfg_q;
	logic              valid_s1;
	logic [7:0]        ch_s1;
	logic              term_s1;
	logic              adv;
	logic              fire;
	logic              load;
	logic              out_valid_q;
	logic [63:0]       value_q;
	dsi_pkg::status_t  status_q;
	logic [63:0]       res_value;
	dsi_pkg::status_t  res_status;
	logic              cfg_wr;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base        <= dsi_pkg::BASE_AUTO;
			cfg_q.signed_mode <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				dsi_pkg::REG_BASE:   cfg_q.base        <= pwdata[4:0];
				dsi_pkg::REG_SIGNED: cfg_q.signed_mode <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			dsi_pkg::REG_BASE:   prdata = {27'd0, cfg_q.base};
			dsi_pkg::REG_SIGNED: prdata = {31'd0, cfg_q.signed_mode};
		endcase
	end

	// Input stage handshake: only a terminator can be held back.
	assign term_s1   = (ch_s1 == dsi_pkg::CH_NUL);
	assign adv       = !term_s1 || !out_valid_q || dout.ready;
	assign fire      = valid_s1 && adv;
	assign load      = fire && term_s1;
	assign din.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.ready && din.valid) begin
			ch_s1 <= din.ch;
		end
	end

	dsi_step #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.ch         (ch_s1),
		.cfg        (cfg_q),
		.res_value  (res_value),
		.res_status (res_status)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q  <= res_value;
			status_q <= res_status;
		end
	end

	assign dout.valid  = out_valid_q;
	assign dout.value  = value_q;
	assign dout.status = status_q;

	// A new result only follows a terminator leaving the input stage.
	a_res_from_term: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && term_s1))
		else $error("result without a terminator");

	// Failed conversions report a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != dsi_pkg::ST_OK)) |-> (value_q == 64'd0))
		else $error("nonzero value with an error status");

	// A held character stays put until the output frees up.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(ch_s1)))
		else $error("input stage lost a held character");

endmodule

`default_nettype wire
